[rtl/lll_pkg.sv]
// ---------------------------------------------------------------------------
// lll_pkg
// Shared constants, codes and types of the Lorentz linear layer.
// ---------------------------------------------------------------------------
`default_nettype none

package lll_pkg;

    localparam int MAX_IN_SIZE  = 64;
    localparam int MAX_OUT_SIZE = 32;

    localparam int POS_W  = (MAX_IN_SIZE > 1) ? $clog2(MAX_IN_SIZE) : 1;
    localparam int ROW_W  = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1;
    localparam int NOUT_W = $clog2(MAX_OUT_SIZE + 1);

    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;
    localparam int SP_W   = 27;   // rounded row value plus bias
    localparam int OUT_W  = 24;
    localparam int SQ_W   = 2 * SP_W;
    localparam int RAD_W  = 60;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int ITER_W = $clog2(ROOT_STEPS);

    localparam logic [1:0] REQ_ELEM   = 2'd0;
    localparam logic [1:0] REQ_WEIGHT = 2'd1;
    localparam logic [1:0] REQ_BIAS   = 2'd2;

    localparam logic [2:0] CFG_IN_SIZE   = 3'd0;
    localparam logic [2:0] CFG_OUT_SIZE  = 3'd1;
    localparam logic [2:0] CFG_INV_CURV  = 3'd2;
    localparam logic [2:0] CFG_BIAS_EN   = 3'd3;

    localparam logic [5:0] OUT_IDX_TIME = 6'd0;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sd8388607;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -24'sd8388608;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_LOAD,
        S_SUM,
        S_TAIL,
        S_ROOT,
        S_TIME,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic mul;
        logic acc;
        logic load;
        logic shift;
        logic bias_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/lll_ram.sv]
// ---------------------------------------------------------------------------
// lll_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module lll_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/lll_cell.sv]
// ---------------------------------------------------------------------------
// lll_cell
// One output row: weight column memory, multiply-accumulate, bias, and a
// value stage that shifts towards the head of the chain.
// ---------------------------------------------------------------------------
`default_nettype none

module lll_cell (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire lll_pkg::t_cell_ctl                     i_ctl,
    input  wire logic                                   i_active,
    input  wire logic                                   i_wrap,
    input  wire logic                                   i_w_we,
    input  wire logic [lll_pkg::POS_W-1:0]              i_w_addr,
    input  wire logic [lll_pkg::VAL_W-1:0]              i_w_data,
    input  wire logic                                   i_b_we,
    input  wire logic [lll_pkg::POS_W-1:0]              i_r_addr,
    input  wire logic signed [lll_pkg::VAL_W-1:0]       i_x,
    input  wire logic signed [lll_pkg::SP_W-1:0]        i_next_s,
    input  wire logic signed [lll_pkg::SP_W-1:0]        i_first_s,
    output logic signed [lll_pkg::SP_W-1:0]             o_s
);
    import lll_pkg::*;

    logic        [VAL_W-1:0]  w_rdata;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [VAL_W-1:0]  r_bias;
    logic signed [SP_W-1:0]   r_s;
    logic signed [ACC_W-1:0]  w_biased;
    logic signed [SP_W-1:0]   w_round;
    logic signed [SP_W-1:0]   w_bias_add;

    lll_ram #(.WIDTH(VAL_W), .DEPTH(MAX_IN_SIZE)) u_wram (
        .i_clk  (i_clk),
        .i_we   (i_w_we),
        .i_waddr(i_w_addr),
        .i_wdata(i_w_data),
        .i_raddr(i_r_addr),
        .o_rdata(w_rdata)
    );

    // round half up from q.26 to q.12
    assign w_biased   = r_acc + ACC_W'(8192);
    assign w_round    = SP_W'(w_biased >>> 14);
    assign w_bias_add = i_ctl.bias_en ? SP_W'(r_bias) : '0;

    always_ff @(posedge i_clk) begin
        if (i_b_we) begin
            r_bias <= i_w_data;
        end
        if (i_ctl.mul) begin
            r_prod <= $signed(w_rdata) * i_x;
        end
        if (i_ctl.load) begin
            r_s <= w_round + w_bias_add;
        end else if (i_ctl.shift) begin
            r_s <= i_wrap ? i_first_s : i_next_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.load) begin
            r_acc <= '0;
        end else if (i_ctl.acc && i_active) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_s = r_s;

endmodule

`default_nettype wire

[rtl/lorentz_linear_layer_top.sv]
// ---------------------------------------------------------------------------
// lorentz_linear_layer_top
// Lorentz linear layer: a chain of row cells multiplies each space element
// into every row, then computes the time component and emits the point.
// ---------------------------------------------------------------------------
//  channel   signals                                   direction
//  request   i_start / o_busy, req_type..value         in
//  result    o_out_valid strobe, out_index..last       out
//  config    i_cfg_valid / o_cfg_ready, index, data    in
//
//  a weight or bias request is written as it is accepted; a non-final element
//  request steps through accept with ram read, multiply and accumulate; a
//  final element then adds the square-sum pass over the chain, the 30-step
//  root unit and the emission of one component a cycle. results cannot be
//  stalled. reset is synchronous, active low; no clearing pass is needed.
`default_nettype none

module lorentz_linear_layer_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic [1:0]                i_req_type,
    input  wire logic [4:0]                i_row_index,
    input  wire logic [5:0]                i_col_index,
    input  wire logic signed [15:0]        i_value,
    output logic                           o_out_valid,
    output logic [5:0]                     o_out_index,
    output logic signed [23:0]             o_out_value,
    output logic                           o_last_of_point,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [2:0]                i_cfg_index,
    input  wire logic [31:0]               i_cfg_data
);
    import lll_pkg::*;

    t_state r_state, n_state;

    logic [6:0]  r_in_size;
    logic [5:0]  r_out_size;
    logic [31:0] r_inv_curv;
    logic        r_bias_en;

    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_last, n_last;
    logic signed [VAL_W-1:0] r_x;
    logic [NOUT_W-1:0]     r_cnt, n_cnt;
    logic [ITER_W-1:0]     r_iter, n_iter;
    logic [SQ_W-1:0]       r_sq, n_sq;
    logic                  r_sqv, n_sqv;
    logic [RAD_W-1:0]      r_rad, n_rad;
    logic [RAD_W-1:0]      r_root, n_root;
    logic [RAD_W-1:0]      r_bit, n_bit;

    logic                  n_out_valid;
    logic [5:0]            n_out_index;
    logic signed [OUT_W-1:0] n_out_value;
    logic                  n_last_of_point;

    logic [8:0]            w_n_in;
    logic [NOUT_W-1:0]     w_n_out;
    logic                  w_accept;
    logic                  w_wr_ok;
    logic                  w_b_ok;
    logic                  w_elem_last;
    logic                  w_cnt_end;
    logic [RAD_W-1:0]      w_trial;
    logic [RAD_W-1:0]      w_t;
    logic signed [SP_W-1:0] w_s0;
    t_cell_ctl             w_ctl;

    logic signed [SP_W-1:0] w_s [MAX_OUT_SIZE];

    // effective sizes
    always_comb begin
        if (r_in_size == 7'd0) begin
            w_n_in = 9'd1;
        end else if (32'(r_in_size) > 32'(MAX_IN_SIZE)) begin
            w_n_in = 9'(MAX_IN_SIZE);
        end else begin
            w_n_in = 9'(r_in_size);
        end
        if (r_out_size == 6'd0) begin
            w_n_out = NOUT_W'(1);
        end else if (32'(r_out_size) > 32'(MAX_OUT_SIZE)) begin
            w_n_out = NOUT_W'(MAX_OUT_SIZE);
        end else begin
            w_n_out = NOUT_W'(r_out_size);
        end
    end

    assign w_accept    = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_wr_ok     = (32'(i_row_index) < 32'(MAX_OUT_SIZE))
                      && (32'(i_col_index) < 32'(MAX_IN_SIZE));
    assign w_b_ok      = (32'(i_row_index) < 32'(MAX_OUT_SIZE));
    assign w_elem_last = (9'(r_pos) + 9'd1) >= w_n_in;
    assign w_cnt_end   = (r_cnt == w_n_out - NOUT_W'(1));
    assign w_s0        = w_s[0];
    assign w_trial     = r_root + r_bit;
    assign w_t         = r_root + ((r_rad > r_root) ? RAD_W'(1) : RAD_W'(0));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_size  <= 7'd64;
            r_out_size <= 6'd32;
            r_inv_curv <= 32'd65536;
            r_bias_en  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IN_SIZE:  r_in_size  <= i_cfg_data[6:0];
                CFG_OUT_SIZE: r_out_size <= i_cfg_data[5:0];
                CFG_INV_CURV: r_inv_curv <= i_cfg_data;
                CFG_BIAS_EN:  r_bias_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // row cell chain
    assign w_ctl.mul     = (r_state == S_MUL);
    assign w_ctl.acc     = (r_state == S_ACC);
    assign w_ctl.load    = (r_state == S_LOAD);
    assign w_ctl.shift   = (r_state == S_SUM) || (r_state == S_EMIT);
    assign w_ctl.bias_en = r_bias_en;

    for (genvar j = 0; j < MAX_OUT_SIZE; j++) begin : g_cell
        logic w_wrap;
        logic signed [SP_W-1:0] w_next;
        if (j == MAX_OUT_SIZE - 1) begin : g_end
            assign w_wrap = 1'b1;
            assign w_next = w_s[0];
        end else begin : g_mid
            assign w_wrap = (32'(w_n_out) == j + 1);
            assign w_next = w_s[j+1];
        end
        lll_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_active (32'(w_n_out) > j),
            .i_wrap   (w_wrap),
            .i_w_we   (w_accept && (i_req_type == REQ_WEIGHT) && w_wr_ok
                       && (32'(i_row_index) == j)),
            .i_w_addr (POS_W'(i_col_index)),
            .i_w_data (i_value),
            .i_b_we   (w_accept && (i_req_type == REQ_BIAS) && w_b_ok
                       && (32'(i_row_index) == j)),
            .i_r_addr (r_pos),
            .i_x      (r_x),
            .i_next_s (w_next),
            .i_first_s(w_s[0]),
            .o_s      (w_s[j])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept && (i_req_type == REQ_ELEM)) n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = r_last ? S_LOAD : S_IDLE;
            S_LOAD: n_state = S_SUM;
            S_SUM:  if (w_cnt_end) n_state = S_TAIL;
            S_TAIL: n_state = S_ROOT;
            S_ROOT: if (r_iter == ITER_W'(ROOT_STEPS - 1)) n_state = S_TIME;
            S_TIME: n_state = S_EMIT;
            S_EMIT: if (w_cnt_end) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_pos           = r_pos;
        n_last          = r_last;
        n_cnt           = r_cnt;
        n_iter          = r_iter;
        n_sq            = r_sq;
        n_sqv           = 1'b0;
        n_rad           = r_rad;
        n_root          = r_root;
        n_bit           = r_bit;
        n_out_valid     = 1'b0;
        n_out_index     = OUT_IDX_TIME;
        n_out_value     = '0;
        n_last_of_point = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_last = w_elem_last;
            end
            S_MUL: ;
            S_ACC: begin
                n_pos = r_last ? '0 : r_pos + POS_W'(1);
            end
            S_LOAD: begin
                n_cnt = '0;
                n_rad = RAD_W'({r_inv_curv, 8'd0});
            end
            S_SUM: begin
                n_sq  = SQ_W'(w_s0 * w_s0);
                n_sqv = 1'b1;
                n_rad = r_rad + (r_sqv ? RAD_W'(r_sq) : '0);
                n_cnt = r_cnt + NOUT_W'(1);
            end
            S_TAIL: begin
                n_rad  = r_rad + RAD_W'(r_sq);
                n_root = '0;
                n_bit  = RAD_W'(1) << (RAD_W - 2);
                n_iter = '0;
            end
            S_ROOT: begin
                if (r_rad >= w_trial) begin
                    n_rad  = r_rad - w_trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit  = r_bit >> 2;
                n_iter = r_iter + ITER_W'(1);
            end
            S_TIME: begin
                n_out_valid = 1'b1;
                n_out_value = (w_t > RAD_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(w_t);
                n_cnt       = '0;
            end
            S_EMIT: begin
                n_out_valid     = 1'b1;
                n_out_index     = 6'(r_cnt) + 6'd1;
                n_last_of_point = w_cnt_end;
                if (w_s0 > SP_W'(OUT_MAX)) begin
                    n_out_value = OUT_MAX;
                end else if (w_s0 < SP_W'(OUT_MIN)) begin
                    n_out_value = OUT_MIN;
                end else begin
                    n_out_value = OUT_W'(w_s0);
                end
                n_cnt = r_cnt + NOUT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_last      <= 1'b0;
            r_sqv       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_last      <= n_last;
            r_sqv       <= n_sqv;
            o_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_value;
        end
        r_cnt           <= n_cnt;
        r_iter          <= n_iter;
        r_sq            <= n_sq;
        r_rad           <= n_rad;
        r_root          <= n_root;
        r_bit           <= n_bit;
        o_out_index     <= n_out_index;
        o_out_value     <= n_out_value;
        o_last_of_point <= n_last_of_point;
    end

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($past(r_state) == S_TIME || $past(r_state) == S_EMIT))
        else $error("result strobe outside emission");

    a_time_then_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_index == OUT_IDX_TIME) |=> o_out_valid)
        else $error("time component not followed by a space output");

    a_last_ends_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_point) |-> (r_state == S_IDLE))
        else $error("last component while point still emitting");

    a_idle_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_pos == '0))
        else $error("element position not cleared at completion");

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Bench for the Lorentz linear layer: fills the weight and bias stores, then
// streams points through a range of size, curvature and bias settings, and
// checks every emitted component against a bit-exact fixed-point predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import lll_pkg::*;

    typedef struct {
        logic [5:0]         idx;
        logic signed [23:0] val;
        logic               last;
    } t_component;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic [1:0]         i_req_type = REQ_ELEM;
    logic [4:0]         i_row_index = '0;
    logic [5:0]         i_col_index = '0;
    logic signed [15:0] i_value = '0;
    logic               i_cfg_valid = 1'b0;
    logic [2:0]         i_cfg_index = CFG_IN_SIZE;
    logic [31:0]        i_cfg_data = '0;
    logic               o_busy;
    logic               o_out_valid;
    logic [5:0]         o_out_index;
    logic signed [23:0] o_out_value;
    logic               o_last_of_point;
    logic               o_cfg_ready;

    lorentz_linear_layer_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_req_type(i_req_type), .i_row_index(i_row_index),
        .i_col_index(i_col_index), .i_value(i_value),
        .o_out_valid(o_out_valid), .o_out_index(o_out_index),
        .o_out_value(o_out_value), .o_last_of_point(o_last_of_point),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic signed [15:0] weights [MAX_OUT_SIZE][MAX_IN_SIZE];
    logic signed [15:0] biases [MAX_OUT_SIZE];
    longint             row_acc [MAX_OUT_SIZE];
    int unsigned        elem_pos;
    logic [6:0]         in_size_reg;
    logic [5:0]         out_size_reg;
    logic [31:0]        inv_curv_reg;
    logic               bias_en_reg;

    t_component pending_components[$];
    int         mismatches = 0;
    bit         gaps_on = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic longint unsigned root_rounded(input longint unsigned v);
        longint unsigned r, b, x;
        r = 0;
        b = 64'd1 << 62;
        x = v;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (x > r) r += 1;
        return r;
    endfunction

    function automatic longint sat_out(input longint v);
        if (v > longint'(OUT_MAX)) return longint'(OUT_MAX);
        if (v < longint'(OUT_MIN)) return longint'(OUT_MIN);
        return v;
    endfunction

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic predict_request(input logic [1:0] kind, input logic [4:0] row,
                                   input logic [5:0] col, input logic signed [15:0] val);
        int unsigned n_in, n_out;
        longint sp [MAX_OUT_SIZE];
        longint s, m;
        longint unsigned rad, t;
        t_component c;
        n_in = clamp_size(in_size_reg, MAX_IN_SIZE);
        n_out = clamp_size(out_size_reg, MAX_OUT_SIZE);
        case (kind)
            REQ_WEIGHT: weights[row][col] = val;
            REQ_BIAS:   biases[row] = val;
            REQ_ELEM: begin
                if (elem_pos < MAX_IN_SIZE)
                    for (int j = 0; j < n_out; j++)
                        row_acc[j] += longint'(weights[j][elem_pos]) * longint'(val);
                if (elem_pos + 1 < n_in) begin
                    elem_pos++;
                end else begin
                    rad = longint'(inv_curv_reg) << 8;
                    for (int j = 0; j < n_out; j++) begin
                        s = (row_acc[j] + 8192) >>> 14;
                        if (bias_en_reg) s += longint'(biases[j]);
                        sp[j] = s;
                        m = (s < 0) ? -s : s;
                        rad += m * m;
                    end
                    t = root_rounded(rad);
                    if (t > longint'(OUT_MAX)) t = longint'(OUT_MAX);
                    c.idx = OUT_IDX_TIME;
                    c.val = t[23:0];
                    c.last = 1'b0;
                    pending_components.push_back(c);
                    for (int j = 0; j < n_out; j++) begin
                        c.idx = 6'(j + 1);
                        c.val = 24'(sat_out(sp[j]));
                        c.last = (j + 1 == n_out);
                        pending_components.push_back(c);
                    end
                    for (int j = 0; j < MAX_OUT_SIZE; j++) row_acc[j] = 0;
                    elem_pos = 0;
                end
            end
            default: ;  // unknown request, ignored
        endcase
    endtask

    task automatic send_request(input logic [1:0] kind, input logic [4:0] row,
                                input logic [5:0] col, input logic signed [15:0] val);
        i_start     <= 1'b1;
        i_req_type  <= kind;
        i_row_index <= row;
        i_col_index <= col;
        i_value     <= val;
        do @(posedge i_clk); while (o_busy);
        predict_request(kind, row, col, val);
        i_start <= 1'b0;
        @(posedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        while (pending_components.size() != 0) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_IN_SIZE:  in_size_reg = data[6:0];
            CFG_OUT_SIZE: out_size_reg = data[5:0];
            CFG_INV_CURV: inv_curv_reg = data;
            CFG_BIAS_EN:  bias_en_reg = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_point(input int n, input bit extreme);
        logic signed [15:0] v;
        for (int k = 0; k < n; k++) begin
            v = extreme ? (k[0] ? -16'sd32768 : 16'sd32767) : 16'($urandom);
            send_request(REQ_ELEM, 5'($urandom), 6'($urandom), v);
        end
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    // every store entry gets written so that no read ever hits an unwritten one
    task automatic test_fill_stores();
        gaps_on = 1'b0;
        for (int r = 0; r < MAX_OUT_SIZE; r++) begin
            send_request(REQ_BIAS, 5'(r), 6'($urandom), pick_value());
            for (int c = 0; c < MAX_IN_SIZE; c++)
                send_request(REQ_WEIGHT, 5'(r), 6'(c), pick_value());
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_directed();
        // saturation with the first two weights at the positive and negative extremes in the first rows
        for (int r = 0; r < 4; r++) begin
            send_request(REQ_WEIGHT, 5'(r), 6'd0, 16'sh7FFF);
            send_request(REQ_WEIGHT, 5'(r), 6'd1, 16'sh8000);
        end
        write_reg(CFG_IN_SIZE, 32'd2);
        write_reg(CFG_OUT_SIZE, 32'd32);
        send_point(2, 1'b1);
        write_reg(CFG_INV_CURV, 32'hFFFF_FFFF);
        write_reg(CFG_BIAS_EN, 32'd1);
        send_point(2, 1'b1);
        write_reg(CFG_INV_CURV, 32'd0);
        send_request(2'd3, 5'h1F, 6'h3F, 16'shFFFF);
        send_point(2, 1'b0);
        // zero sizes clamp up to one
        write_reg(CFG_IN_SIZE, 32'd0);
        write_reg(CFG_OUT_SIZE, 32'd0);
        send_point(1, 1'b0);
        write_reg(CFG_BIAS_EN, 32'd0);
        // oversized counts clamp to the maxima
        write_reg(CFG_OUT_SIZE, 32'd63);
        write_reg(CFG_IN_SIZE, 32'd127);
        write_reg(CFG_INV_CURV, 32'd65536);
        send_point(MAX_IN_SIZE, 1'b0);
    endtask

    // input size cut below the position reached makes the next element the last
    task automatic test_shrink_mid_point();
        write_reg(CFG_IN_SIZE, 32'd8);
        write_reg(CFG_OUT_SIZE, 32'd5);
        send_point(5, 1'b0);
        write_reg(CFG_IN_SIZE, 32'd3);
        send_point(1, 1'b0);
        send_point(3, 1'b0);
    endtask

    task automatic test_random();
        int sent;
        int n_in;
        sent = 0;
        while (sent < 380) begin
            if (sent > 300) gaps_on = 1'b0;
            n_in = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
            write_reg(CFG_IN_SIZE, 32'(n_in));
            write_reg(CFG_OUT_SIZE, 32'($urandom_range(0, 8) == 0 ? $urandom_range(0, 63)
                                                                : $urandom_range(1, 32)));
            if ($urandom_range(0, 2) == 0) write_reg(CFG_INV_CURV, $urandom);
            if ($urandom_range(0, 2) == 0) write_reg(CFG_BIAS_EN, 32'($urandom_range(0, 1)));
            for (int p = 0; p < $urandom_range(1, 4); p++) begin
                for (int k = 0; k < n_in; k++) begin
                    case ($urandom_range(0, 11))
                        0: send_request(REQ_WEIGHT, 5'($urandom), 6'($urandom), pick_value());
                        1: send_request(REQ_BIAS, 5'($urandom), 6'($urandom), pick_value());
                        2: send_request(2'd3, 5'($urandom), 6'($urandom), 16'($urandom));
                        default: ;
                    endcase
                    send_request(REQ_ELEM, 5'($urandom), 6'($urandom), pick_value());
                    sent++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_component e;
        if (i_rst_n && o_out_valid) begin
            if (pending_components.size() == 0) begin
                report_mismatch($sformatf("unexpected component idx %0d", o_out_index));
            end else begin
                e = pending_components.pop_front();
                if (o_out_index !== e.idx)
                    report_mismatch($sformatf("index %0d, want %0d", o_out_index, e.idx));
                if (o_out_value !== e.val)
                    report_mismatch($sformatf("idx %0d value %0d, want %0d",
                                              e.idx, o_out_value, e.val));
                if (o_last_of_point !== e.last)
                    report_mismatch($sformatf("idx %0d last %b, want %b",
                                              e.idx, o_last_of_point, e.last));
            end
        end
    end

    initial begin
        for (int j = 0; j < MAX_OUT_SIZE; j++) row_acc[j] = 0;
        elem_pos = 0;
        in_size_reg = 7'd64;
        out_size_reg = 6'd32;
        inv_curv_reg = 32'd65536;
        bias_en_reg = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_stores();
        test_directed();
        test_shrink_mid_point();
        test_random();
        while (pending_components.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/lll_pkg.sv
rtl/lll_ram.sv
rtl/lll_cell.sv
rtl/lorentz_linear_layer_top.sv
bench/tb_top.sv
